FILE: src/edit_distance_engine_defines.svh
// Assertion macros shared by the checker of the edit distance engine.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// same-cycle implication
`define EDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/eds_pkg.sv
// Package of the edit distance engine: sizes, opcodes, controller types.
// No dependencies.
`default_nettype none
package eds_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 7;
    localparam int DIST_MAX    = 127;

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_CELL
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_direct;
        logic init_begin;
        logic init_write;
        logic row_begin;
        logic cell_step;
        logic emit_cell;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic j_last;
        logic i_last;
    } t_status;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [31:0] d);
        logic [DIST_W-1:0] res;
        if (d > 32'(DIST_MAX)) begin
            res = DIST_W'(DIST_MAX);
        end else begin
            res = d[DIST_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: src/eds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module eds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/eds_ctrl.sv
// Controller of the edit distance engine: sequences loads, row init and cell sweep.
// Depends on eds_pkg.
`default_nettype none
module eds_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [eds_pkg::OP_W-1:0]  i_opcode,
    input  wire eds_pkg::t_status          i_status,
    output eds_pkg::t_cmd                  o_cmd,
    output logic                           o_busy
);
    import eds_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_COMPUTE) begin
                        if (i_status.empty) begin
                            cmd.emit_direct = 1'b1;
                        end else begin
                            cmd.init_begin = 1'b1;
                            n_state        = S_INIT;
                        end
                    end else if (i_opcode == OP_APPEND_FIRST ||
                                 i_opcode == OP_APPEND_SECOND) begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_INIT: begin
                cmd.init_write = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                cmd.row_begin = 1'b1;
                n_state       = S_CELL;
            end
            S_CELL: begin
                cmd.cell_step = 1'b1;
                if (i_status.j_last) begin
                    if (i_status.i_last) begin
                        cmd.emit_cell = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_ROW;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

FILE: src/eds_datapath.sv
// Datapath of the edit distance engine: string stores, cost row, cell update.
// Depends on eds_pkg and eds_ram.
`default_nettype none
module eds_datapath #(
    parameter int MAX_LEN = eds_pkg::MAX_LEN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire eds_pkg::t_cmd               i_cmd,
    output eds_pkg::t_status                 o_status,
    input  wire logic [eds_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [eds_pkg::CHAR_W-1:0]  i_char_in,
    output logic                             o_valid,
    output logic [eds_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_truncated
);
    import eds_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = LW;
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

    logic [LW-1:0]     r_len_a, n_len_a;
    logic [LW-1:0]     r_len_b, n_len_b;
    logic              r_ovf, n_ovf;
    logic [LW-1:0]     r_i, n_i;
    logic [LW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_diag, n_diag;
    logic              r_valid, n_valid;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_trunc, n_trunc;

    logic              we_a, we_b, re_row, re_cell;
    logic [CHAR_W-1:0] ch_a, ch_b;
    logic [CW-1:0]     above;
    logic              cost_we;
    logic [CW-1:0]     cost_wdata;
    logic [AW-1:0]     cell_raddr;
    logic [LW-1:0]     i_dec, j_dec;
    logic [CW:0]       c_up, c_left, c_diag, c_min;
    logic [CW-1:0]     cell_val;
    t_status           status;

    assign status.empty  = (r_len_a == '0) || (r_len_b == '0);
    assign status.j_last = (r_j == r_len_b);
    assign status.i_last = (r_i == r_len_a);
    assign o_status      = status;

    assign i_dec = r_i - LW'(1);
    assign j_dec = r_j - LW'(1);

    assign we_a = i_cmd.load && (i_opcode == OP_APPEND_FIRST) && (r_len_a != FULL);
    assign we_b = i_cmd.load && (i_opcode == OP_APPEND_SECOND) && (r_len_b != FULL);

    assign re_row     = i_cmd.row_begin;
    assign re_cell    = re_row || (i_cmd.cell_step && !status.j_last);
    assign cell_raddr = re_row ? '0 : r_j[AW-1:0];

    assign cost_we    = i_cmd.init_write || i_cmd.cell_step;
    assign cost_wdata = i_cmd.init_write ? r_j : cell_val;

    eds_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_text (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_len_a[AW-1:0]),
        .i_wdata (i_char_in),
        .i_re    (re_row),
        .i_raddr (i_dec[AW-1:0]),
        .o_rdata (ch_a)
    );

    eds_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_text (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_len_b[AW-1:0]),
        .i_wdata (i_char_in),
        .i_re    (re_cell),
        .i_raddr (cell_raddr),
        .o_rdata (ch_b)
    );

    eds_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_cost_row (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (j_dec[AW-1:0]),
        .i_wdata (cost_wdata),
        .i_re    (re_cell),
        .i_raddr (cell_raddr),
        .o_rdata (above)
    );

    always_comb begin
        c_up   = {1'b0, above} + (CW+1)'(1);
        c_left = {1'b0, r_left} + (CW+1)'(1);
        c_diag = {1'b0, r_diag} + (CW+1)'(ch_a != ch_b);
        c_min  = (c_up < c_left) ? c_up : c_left;
        if (c_diag < c_min) begin
            c_min = c_diag;
        end
        cell_val = c_min[CW-1:0];
    end

    always_comb begin
        n_len_a = r_len_a;
        n_len_b = r_len_b;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        n_left  = r_left;
        n_diag  = r_diag;
        n_valid = 1'b0;
        n_dist  = r_dist;
        n_trunc = r_trunc;

        if (i_cmd.load) begin
            if (i_opcode == OP_APPEND_FIRST) begin
                if (r_len_a != FULL) begin
                    n_len_a = r_len_a + LW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                if (r_len_b != FULL) begin
                    n_len_b = r_len_b + LW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
        if (i_cmd.init_begin) begin
            n_i = LW'(1);
            n_j = LW'(1);
        end
        if (i_cmd.init_write) begin
            n_j = r_j + LW'(1);
        end
        if (i_cmd.row_begin) begin
            n_left = r_i;
            n_diag = i_dec;
            n_j    = LW'(1);
        end
        if (i_cmd.cell_step) begin
            n_left = cell_val;
            n_diag = above;
            n_j    = r_j + LW'(1);
            if (status.j_last && !status.i_last) begin
                n_i = r_i + LW'(1);
            end
        end
        if (i_cmd.emit_direct || i_cmd.emit_cell) begin
            if (i_cmd.emit_cell) begin
                n_dist = sat_dist(32'(cell_val));
            end else if (r_len_a == '0) begin
                n_dist = sat_dist(32'(r_len_b));
            end else begin
                n_dist = sat_dist(32'(r_len_a));
            end
            n_trunc = r_ovf;
            n_valid = 1'b1;
            n_len_a = '0;
            n_len_b = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_len_a <= n_len_a;
            r_len_b <= n_len_b;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_diag  <= n_diag;
        r_dist  <= n_dist;
        r_trunc <= n_trunc;
    end

    assign o_valid     = r_valid;
    assign o_distance  = r_dist;
    assign o_truncated = r_trunc;

endmodule
`default_nettype wire

FILE: src/edit_distance_engine.sv
// Top level of the Levenshtein edit distance engine.
// Depends on eds_pkg, eds_ctrl, eds_datapath and eds_ram.
//
// Usage: a word is taken on start while busy is low. Opcode 0 appends
// i_char_in to the first string, opcode 1 to the second; a load never
// raises busy. Opcode 2 computes the distance, shows
// it on o_distance/o_truncated for one cycle with o_valid, and empties
// both strings. Opcode 3 is ignored.
// Compute result: with an empty string, o_valid follows in the cycle after
// the word. Otherwise busy stays high through the init pass and the row
// sweep, and o_valid comes in the same cycle as busy falls.
// The sweep steps the cost-row RAM one cell per cycle on its read/write
// ports, with a row-start state before the row of each first-string byte.
// Bytes past MAX_LEN are dropped and flagged on o_truncated.
// Reset empties both strings and returns to idle with no result pending.
// The receiver cannot stall: o_valid is a single-cycle strobe.
`default_nettype none
module edit_distance_engine #(
    parameter int MAX_LEN = eds_pkg::MAX_LEN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [eds_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [eds_pkg::CHAR_W-1:0]  i_char_in,
    output logic                             o_valid,
    output logic [eds_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_truncated
);
    import eds_pkg::*;

    t_cmd    cmd;
    t_status status;

    eds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    eds_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_opcode    (i_opcode),
        .i_char_in   (i_char_in),
        .o_valid     (o_valid),
        .o_distance  (o_distance),
        .o_truncated (o_truncated)
    );

endmodule
`default_nettype wire

FILE: src/eds_checker.sv
// Port-level checker of the edit distance engine, bound to the top level.
// Depends on eds_pkg and edit_distance_engine_defines.svh.
`include "edit_distance_engine_defines.svh"
`default_nettype none
module eds_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [eds_pkg::OP_W-1:0]    i_opcode,
    input wire logic [eds_pkg::CHAR_W-1:0]  i_char_in,
    input wire logic                        o_valid,
    input wire logic [eds_pkg::DIST_W-1:0]  o_distance,
    input wire logic                        o_truncated
);
    import eds_pkg::*;

    `EDS_ASSERT_NOW(a_busy_from_compute, $rose(busy), $past(start) && $past(i_opcode == OP_COMPUTE), "busy rose without a compute word")
    `EDS_ASSERT_NEXT(a_load_no_busy, start && !busy && i_opcode != OP_COMPUTE, !busy, "load word raised busy")
    `EDS_ASSERT_NOW(a_valid_source, o_valid, $past(busy) || ($past(start) && $past(i_opcode == OP_COMPUTE)), "result without a compute")
    `EDS_ASSERT_NOW(a_idle_after_sweep, o_valid && $past(busy), !busy, "still busy after result")

endmodule

bind edit_distance_engine eds_checker u_eds_checker (.*);
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of edit_distance_engine: string loads, computes, full strings, noise.
// Predicts distances by its own dynamic program unless typed, and checks each strobed result.
// Depends on eds_pkg and the edit_distance_engine RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eds_pkg::*;

    localparam int              LEN_MAX   = MAX_LEN_DEF;
    localparam int              WORD_GOAL = 1900;
    localparam int              LONG_GOAL = 12;
    localparam int              RING_D    = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              trunc;
    } dist_word_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic              typed;
        logic [DIST_W-1:0] dist_val;
        logic              trunc;
    } stim_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    logic [CHAR_W-1:0] i_char_in;
    logic              o_valid;
    logic [DIST_W-1:0] o_distance;
    logic              o_truncated;

    edit_distance_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_char_in   (i_char_in),
        .o_valid     (o_valid),
        .o_distance  (o_distance),
        .o_truncated (o_truncated)
    );

    logic [CHAR_W-1:0] str_a [LEN_MAX];
    logic [CHAR_W-1:0] str_b [LEN_MAX];
    int                len_a;
    int                len_b;
    logic              cut_seen;

    dist_word_t        exp_ring [RING_D];
    int                exp_wr;
    int                exp_rd;
    int                errors;
    int                words_sent;
    int                results_seen;
    int                trunc_seen;
    int                long_pairs;
    bit                quiet;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned lev_distance();
        int unsigned row [LEN_MAX+1];
        int unsigned diag;
        int unsigned above;
        int unsigned best;
        int unsigned sub;
        for (int j = 0; j <= len_b; j++) row[j] = j;
        for (int i = 1; i <= len_a; i++) begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= len_b; j++) begin
                above = row[j];
                sub   = (str_a[i-1] == str_b[j-1]) ? 0 : 1;
                best  = above + 1;
                if (row[j-1] + 1 < best) best = row[j-1] + 1;
                if (diag + sub < best) best = diag + sub;
                row[j] = best;
                diag   = above;
            end
        end
        return row[len_b];
    endfunction

    task automatic put_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic typed = 1'b0, input logic [DIST_W-1:0] tdist = '0,
                            input logic ttrunc = 1'b0);
        int unsigned d;
        dist_word_t  w;
        i_opcode  <= op;
        i_char_in <= ch;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (op != OP_UNUSED) words_sent++;
        case (op)
            OP_APPEND_FIRST: begin
                if (len_a < LEN_MAX) begin
                    str_a[len_a] = ch;
                    len_a++;
                end else begin
                    cut_seen = 1'b1;
                end
            end
            OP_APPEND_SECOND: begin
                if (len_b < LEN_MAX) begin
                    str_b[len_b] = ch;
                    len_b++;
                end else begin
                    cut_seen = 1'b1;
                end
            end
            OP_COMPUTE: begin
                d = lev_distance();
                if (d > DIST_MAX) d = DIST_MAX;
                w.dist_val = d[DIST_W-1:0];
                w.trunc    = cut_seen;
                if (typed) begin
                    w.dist_val = tdist;
                    w.trunc    = ttrunc;
                end
                exp_ring[exp_wr % RING_D] = w;
                exp_wr++;
                len_a    = 0;
                len_b    = 0;
                cut_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(input bit narrow);
        return narrow ? CHAR_W'(8'h61 + $urandom_range(2)) : CHAR_W'($urandom_range(255));
    endfunction

    task automatic random_pair();
        int  n_a;
        int  n_b;
        bit  narrow;
        bit  go_a;
        if ($urandom_range(99) < 4 && long_pairs < LONG_GOAL) begin
            n_a = $urandom_range(40, LEN_MAX + 2);
            n_b = $urandom_range(0, LEN_MAX + 2);
            long_pairs++;
        end else begin
            n_a = $urandom_range(0, ($urandom_range(9) == 0) ? 12 : 6);
            n_b = $urandom_range(0, ($urandom_range(9) == 0) ? 12 : 6);
        end
        narrow = ($urandom_range(99) < 60);
        while (n_a + n_b > 0) begin
            if (n_a == 0)      go_a = 1'b0;
            else if (n_b == 0) go_a = 1'b1;
            else               go_a = 1'($urandom_range(1));
            if (go_a) begin
                put_word(OP_APPEND_FIRST, pick_char(narrow));
                n_a--;
            end else begin
                put_word(OP_APPEND_SECOND, pick_char(narrow));
                n_b--;
            end
            maybe_idle();
            if ($urandom_range(99) < 5) begin
                put_word(OP_UNUSED, CHAR_W'($urandom_range(255)));
                maybe_idle();
            end
        end
        put_word(OP_COMPUTE, CHAR_W'($urandom_range(255)));
        maybe_idle();
    endtask

    always @(posedge i_clk) begin
        dist_word_t w;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result distance=%0d truncated=%0b",
                         $time, o_distance, o_truncated);
                errors++;
            end else begin
                w = exp_ring[exp_rd % RING_D];
                exp_rd++;
                results_seen++;
                if (w.trunc) trunc_seen++;
                if (o_distance !== w.dist_val) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, w.dist_val, o_distance);
                    errors++;
                end
                if (o_truncated !== w.trunc) begin
                    $display("%0t: truncated expected %0b actual %0b",
                             $time, w.trunc, o_truncated);
                    errors++;
                end
            end
        end
    end

    stim_row_t dir_rows [24];

    initial begin
        logic [CHAR_W-1:0] fill [LEN_MAX];
        errors       = 0;
        words_sent   = 0;
        results_seen = 0;
        trunc_seen   = 0;
        long_pairs   = 0;
        exp_wr       = 0;
        exp_rd       = 0;
        quiet        = 1'b0;
        len_a        = 0;
        len_b        = 0;
        cut_seen     = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_opcode     <= OP_APPEND_FIRST;
        i_char_in    <= '0;

        dir_rows = '{
            '{OP_COMPUTE,       8'h00, 1'b1, 7'd0, 1'b0},
            '{OP_UNUSED,        8'hFF, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'h00, 1'b1, 7'd0, 1'b0},
            '{OP_APPEND_FIRST,  8'h00, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'hFF, 1'b1, 7'd1, 1'b0},
            '{OP_APPEND_SECOND, 8'hFF, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'hFF, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'h00, 1'b1, 7'd2, 1'b0},
            '{OP_APPEND_FIRST,  8'h00, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h00, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'h00, 1'b1, 7'd0, 1'b0},
            '{OP_APPEND_FIRST,  8'hFF, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h00, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'h00, 1'b1, 7'd1, 1'b0},
            '{OP_APPEND_FIRST,  8'h6B, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_FIRST,  8'h69, 1'b0, 7'd0, 1'b0},
            '{OP_UNUSED,        8'h78, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_FIRST,  8'h74, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h73, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h69, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h74, 1'b0, 7'd0, 1'b0},
            '{OP_UNUSED,        8'h55, 1'b0, 7'd0, 1'b0},
            '{OP_APPEND_SECOND, 8'h65, 1'b0, 7'd0, 1'b0},
            '{OP_COMPUTE,       8'hAA, 1'b0, 7'd0, 1'b0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            put_word(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].typed,
                     dir_rows[k].dist_val, dir_rows[k].trunc);
            maybe_idle();
        end

        // full strings: overflow the first, then two full equal strings, second overflowed
        for (int k = 0; k <= LEN_MAX; k++) put_word(OP_APPEND_FIRST, CHAR_W'($urandom_range(255)));
        put_word(OP_COMPUTE, 8'h00, 1'b1, DIST_W'(LEN_MAX), 1'b1);
        for (int k = 0; k < LEN_MAX; k++) fill[k] = CHAR_W'($urandom_range(255));
        for (int k = 0; k < LEN_MAX; k++) begin
            put_word(OP_APPEND_FIRST, fill[k]);
            put_word(OP_APPEND_SECOND, fill[k]);
            maybe_idle();
        end
        put_word(OP_APPEND_SECOND, 8'h5A);
        put_word(OP_COMPUTE, 8'h00, 1'b1, 7'd0, 1'b1);
        put_word(OP_COMPUTE, 8'h00, 1'b1, 7'd0, 1'b0);
        drain_results();

        while (words_sent < WORD_GOAL) begin
            quiet = (words_sent > 1200 && words_sent < 1500);
            random_pair();
            if (words_sent > 950 && words_sent < 970) drain_results();
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d words, checked %0d distances (%0d truncated, %0d long pairs)",
                 words_sent, results_seen, trunc_seen, long_pairs);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
